[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/vkt_pkg.sv]
// ----------------------------------------------------------------------------
// vkt_pkg
// Shared codes and chain types for the versioned key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vkt_pkg;

	localparam int VER_W = 10;
	localparam int KEY_W = 64;

	localparam logic [VER_W-1:0] SPECIAL_VER    = 10'd999;
	localparam logic [VER_W-1:0] TOP_NORMAL_VER = 10'd255;

	// Commands
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;
	localparam logic [1:0] CMD_LATEST = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_IN_USE    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// One table slot
	typedef struct packed {
		logic [VER_W-1:0] ver;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Probe that walks the chain one cell per cycle. In find mode ver is the
	// version searched for; in latest mode it is the best version so far.
	typedef struct packed {
		logic             valid;
		logic             latest;
		logic             hit;
		logic [VER_W-1:0] ver;
		logic [KEY_W-1:0] key;
	} probe_t;

	// Update strobes broadcast to every cell when a command commits.
	typedef struct packed {
		logic             append;
		logic             overwrite;
		logic             shift_dn;
		logic [VER_W-1:0] ver;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

[hdl/vkt_cell.sv]
// ----------------------------------------------------------------------------
// vkt_cell
// One table slot plus one stage of the search probe chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vkt_cell #(
	parameter int IDX = 0,
	parameter int CW  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CW-1:0]      count,
	input  vkt_pkg::cell_ctrl_t ctrl,
	input  vkt_pkg::probe_t    probe_in,
	output vkt_pkg::probe_t    probe_out,
	input  vkt_pkg::entry_t    nbr,
	output vkt_pkg::entry_t    entry
);

	vkt_pkg::entry_t ent_q;
	vkt_pkg::probe_t probe_q;
	vkt_pkg::probe_t probe_nxt;
	logic            sel_q;
	logic            shift_q;
	logic            occupied;
	logic            match;
	logic            cand;

	assign occupied = CW'(IDX) < count;

	always_comb begin
		match = probe_in.valid && !probe_in.latest && occupied && !probe_in.hit &&
			(ent_q.ver == probe_in.ver);
		cand  = probe_in.valid && probe_in.latest && occupied &&
			(ent_q.ver != vkt_pkg::SPECIAL_VER) &&
			(!probe_in.hit || (ent_q.ver > probe_in.ver));
		probe_nxt = probe_in;
		if (match || cand) begin
			probe_nxt.hit = 1'b1;
			probe_nxt.ver = ent_q.ver;
			probe_nxt.key = ent_q.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
			sel_q   <= 1'b0;
			shift_q <= 1'b0;
		end else begin
			probe_q <= probe_nxt;
			if (probe_in.valid && !probe_in.latest) begin
				sel_q   <= match;
				shift_q <= match || probe_in.hit;
			end
		end
	end

	// Slot contents carry no reset
	always_ff @(posedge clk) begin
		priority if (ctrl.shift_dn && shift_q) begin
			ent_q <= nbr;
		end else if (ctrl.overwrite && sel_q) begin
			ent_q.key <= ctrl.key;
		end else if (ctrl.append && (count == CW'(IDX))) begin
			ent_q.ver <= ctrl.ver;
			ent_q.key <= ctrl.key;
		end
	end

	assign probe_out = probe_q;
	assign entry     = ent_q;

endmodule

[hdl/versioned_key_table_core.sv]
// ----------------------------------------------------------------------------
// versioned_key_table_core
// Table of up to MAX_KEYS 64-bit keys tagged with versions, built as a row
// of slot cells that a search probe walks through.
// ----------------------------------------------------------------------------
// Each command is taken as one transfer and answered with exactly one result
// transfer. Commands are handled one at a time: after a command is accepted,
// a probe walks the row of slot cells one cell per clock. The probe that leaves
// the chain is registered, then the result is loaded into the output register
// once that register is free or being drained, and s_tready rises again at the
// same time. The length of the cell chain sets how long the walk lasts. A
// waiting result does not hold off the next command; only a second finished
// result waits until the first one is taken. The table is empty after reset;
// slots beyond the entry count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module versioned_key_table_core #(
	parameter int MAX_KEYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // version[9:0], allow_overwrite[10], key_in[74:11], zero
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // status[2:0], key_out[66:3], version_out[76:67], zero
);

	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]                  state_q;
	logic [CW-1:0]               count_q;
	logic [1:0]                  cmd_q;
	logic                        over_q;
	logic [vkt_pkg::VER_W-1:0]   ver_q;
	logic [vkt_pkg::KEY_W-1:0]   key_q;
	vkt_pkg::probe_t             launch_q;
	vkt_pkg::probe_t             res_q;
	logic                        m_tvalid_q;
	logic [79:0]                 m_tdata_q;

	vkt_pkg::probe_t             probe_w [MAX_KEYS+1];
	vkt_pkg::entry_t             ent_w   [MAX_KEYS];
	vkt_pkg::cell_ctrl_t         ctrl;

	logic                        s_fire;
	logic                        commit;
	logic                        in_range;
	logic                        cnt_inc;
	logic                        cnt_dec;
	logic [2:0]                  status;
	logic [vkt_pkg::KEY_W-1:0]   kout;
	logic [vkt_pkg::VER_W-1:0]   vout;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	// Commit once the output register is free or being drained this cycle
	assign commit   = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign probe_w[0] = launch_q;

	// Row of slot cells; the last one shifts in its own contents on delete
	for (genvar gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
		vkt_pkg::entry_t nbr;
		if (gi == MAX_KEYS - 1) begin : g_last
			assign nbr = ent_w[gi];
		end else begin : g_mid
			assign nbr = ent_w[gi+1];
		end
		vkt_cell #(
			.IDX (gi),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.ctrl      (ctrl),
			.probe_in  (probe_w[gi]),
			.probe_out (probe_w[gi+1]),
			.nbr       (nbr),
			.entry     (ent_w[gi])
		);
	end

	// Decide the outcome from the probe that left the chain
	always_comb begin
		in_range = (ver_q == vkt_pkg::SPECIAL_VER) || (ver_q <= vkt_pkg::TOP_NORMAL_VER);
		status   = vkt_pkg::ST_OK;
		kout     = '0;
		vout     = '0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		ctrl     = '0;
		ctrl.ver = ver_q;
		ctrl.key = key_q;
		unique case (cmd_q)
			vkt_pkg::CMD_ADD: begin
				if (!in_range) begin
					status = vkt_pkg::ST_RANGE;
				end else if (res_q.hit) begin
					if (over_q) begin
						ctrl.overwrite = commit;
					end else begin
						status = vkt_pkg::ST_IN_USE;
					end
				end else if (count_q == CW'(MAX_KEYS)) begin
					status = vkt_pkg::ST_FULL;
				end else begin
					ctrl.append = commit;
					cnt_inc     = commit;
				end
			end
			vkt_pkg::CMD_DELETE: begin
				if (res_q.hit) begin
					ctrl.shift_dn = commit;
					cnt_dec       = commit;
				end else begin
					status = vkt_pkg::ST_NOT_FOUND;
				end
			end
			vkt_pkg::CMD_GET: begin
				if (res_q.hit) begin
					kout = res_q.key;
				end else begin
					status = vkt_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				if (res_q.hit) begin
					kout = res_q.key;
					vout = res_q.ver;
				end else begin
					status = vkt_pkg::ST_NOT_FOUND;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			launch_q   <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Launch a probe only in the cycle after a command transfer
			launch_q.valid <= s_fire;
			// Load a finished result, or drop the one the sink just took
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						// Load the probe for the first cell
						launch_q.latest <= (s_tuser == vkt_pkg::CMD_LATEST);
						launch_q.hit    <= 1'b0;
						launch_q.ver    <= s_tdata[9:0];
						launch_q.key    <= '0;
						state_q         <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (probe_w[MAX_KEYS].valid) begin
						res_q   <= probe_w[MAX_KEYS];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (cnt_inc) begin
							count_q <= count_q + 1'b1;
						end else if (cnt_dec) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command and result payload; no reset needed
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q  <= s_tuser;
			ver_q  <= s_tdata[9:0];
			over_q <= s_tdata[10];
			key_q  <= s_tdata[74:11];
		end
		if (commit) begin
			m_tdata_q <= {3'b000, vout, kout, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_KEYS), "entry count exceeds table size")
	`ASSERT_IMPL(a_count_commit, count_q != $past(count_q), $past(state_q) == S_FIN,
		"entry count moved outside a commit")
	`ASSERT_IMPL(a_result_commit, $rose(m_tvalid), $past(state_q) == S_FIN,
		"result raised without a commit")
	`ASSERT_IMPL(a_probe_scan, probe_w[MAX_KEYS].valid, state_q == S_SCAN,
		"probe left the chain outside a scan")

endmodule

[sim/versioned_key_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_key_table_checker
// Watches both streams of the key table, keeps its own copy of the table and
// compares every result transfer with the answer owed to the oldest command.
// ----------------------------------------------------------------------------

module versioned_key_table_checker #(
	parameter int MAX_KEYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,  // version[9:0], allow_overwrite[10], key_in[74:11], zero
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // status[2:0], key_out[66:3], version_out[76:67], zero
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [2:0]                status;
		logic [vkt_pkg::KEY_W-1:0] key;
		logic [vkt_pkg::VER_W-1:0] ver;
	} answer_t;

	logic [vkt_pkg::VER_W-1:0] slot_ver [MAX_KEYS];
	logic [vkt_pkg::KEY_W-1:0] slot_key [MAX_KEYS];
	int                        used;
	answer_t                   owed_answers [$];
	int                        errors;
	int                        matched;

	// Slot of the first entry holding version v, or used if none does.
	function automatic int first_slot(input logic [vkt_pkg::VER_W-1:0] v);
		int i;
		for (i = 0; i < used; i++)
			if (slot_ver[i] == v)
				return i;
		return used;
	endfunction

	// Apply one command to the table copy and return the answer it owes.
	function automatic answer_t run_table_command(input logic [1:0] cmd,
		input logic [vkt_pkg::VER_W-1:0] v, input logic over,
		input logic [vkt_pkg::KEY_W-1:0] k);
		answer_t a;
		int      i;
		logic    found;
		a        = '0;
		a.status = vkt_pkg::ST_OK;
		found    = 1'b0;
		case (cmd)
		vkt_pkg::CMD_ADD: begin
			i = first_slot(v);
			if (v != vkt_pkg::SPECIAL_VER && v > vkt_pkg::TOP_NORMAL_VER)
				a.status = vkt_pkg::ST_RANGE;
			else if (i < used) begin
				if (!over)
					a.status = vkt_pkg::ST_IN_USE;
				else
					slot_key[i] = k;
			end else if (used >= MAX_KEYS)
				a.status = vkt_pkg::ST_FULL;
			else begin
				slot_ver[used] = v;
				slot_key[used] = k;
				used++;
			end
		end
		vkt_pkg::CMD_DELETE: begin
			i = first_slot(v);
			if (i >= used)
				a.status = vkt_pkg::ST_NOT_FOUND;
			else begin
				for (; i + 1 < used; i++) begin
					slot_ver[i] = slot_ver[i+1];
					slot_key[i] = slot_key[i+1];
				end
				used--;
			end
		end
		vkt_pkg::CMD_GET: begin
			i = first_slot(v);
			if (i < used)
				a.key = slot_key[i];
			else
				a.status = vkt_pkg::ST_NOT_FOUND;
		end
		default: begin
			// skip the special version; strict compare keeps the earliest on a tie
			for (i = 0; i < used; i++) begin
				if (slot_ver[i] != vkt_pkg::SPECIAL_VER &&
					(!found || slot_ver[i] > a.ver)) begin
					found = 1'b1;
					a.ver = slot_ver[i];
					a.key = slot_key[i];
				end
			end
			if (!found)
				a.status = vkt_pkg::ST_NOT_FOUND;
		end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			used = 0;
			owed_answers.delete();
			errors  = 0;
			matched = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			// retire the result first: it can only belong to an earlier command
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.key    = m_tdata[66:3];
				got.ver    = m_tdata[76:67];
				if (owed_answers.size() == 0) begin
					$error("result transfer with no command outstanding (status %0d)",
						got.status);
					errors++;
				end else begin
					want = owed_answers.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.key !== want.key) begin
						$error("key_out: expected %h, got %h", want.key, got.key);
						errors++;
					end
					if (got.ver !== want.ver) begin
						$error("version_out: expected %0d, got %0d", want.ver, got.ver);
						errors++;
					end
					matched++;
				end
			end
			if (s_tvalid && s_tready)
				owed_answers.push_back(run_table_command(s_tuser, s_tdata[9:0],
					s_tdata[10], s_tdata[74:11]));
			fail_count <= errors;
			pending    <= owed_answers.size();
			checked    <= matched;
		end
	end

endmodule

[sim/versioned_key_table_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_key_table_core_test
// Drives commands into the versioned key table and reports the verdict.
// A directed opening walks through range errors, the special version, in-use
// and overwrite, a full table and slide-down on delete; random traffic then
// swings the table between empty and full under random idling on both sides,
// a long result-side stall and drain pauses. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------

module versioned_key_table_core_test;

	localparam int MAX_KEYS       = 8;
	localparam int LATENCY        = MAX_KEYS + 2;
	localparam int IDLE_PCT       = 7;
	localparam int LONG_HOLD      = 400;
	// longest correct stretch with no transfer is the long hold plus one command
	localparam int WATCHDOG_LIMIT = 10 * LONG_HOLD;
	localparam int TAIL_CYCLES    = 4 * LATENCY;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;   // version[9:0], allow_overwrite[10], key_in[74:11], zero
	logic [1:0]  s_tuser  = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;         // status[2:0], key_out[66:3], version_out[76:67], zero

	int fail_count;
	int pending;
	int checked;
	int idle_cycles = 0;
	int cmd_sent [4] = '{0, 0, 0, 0};

	// steady: no idling on either side; hold_request: ask the sink for a long stall
	bit steady       = 1'b0;
	bit hold_request = 1'b0;

	versioned_key_table_core #(
		.MAX_KEYS(MAX_KEYS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	versioned_key_table_checker #(
		.MAX_KEYS(MAX_KEYS)
	) answer_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	always #5 clk = ~clk;

	// Result sink: take results with random back-pressure, or hold off for
	// a long stretch when asked so the block fills up and stalls its input.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run if no transfer happens on either stream for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Offer one command and hold it until the transfer. Entered right after
	// an edge, so at most one assignment to s_tvalid lands in this step.
	task automatic send_command(input logic [1:0] cmd,
		input logic [vkt_pkg::VER_W-1:0] v, input logic over,
		input logic [vkt_pkg::KEY_W-1:0] k);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, k, over, v};
		cmd_sent[cmd]++;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and pause until every owed result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Versions: mostly a small pool so commands hit stored entries, plus
	// random normal versions, full-range noise and the edges of the range.
	function automatic logic [vkt_pkg::VER_W-1:0] pick_version();
		int                        sel;
		logic [vkt_pkg::VER_W-1:0] v;
		sel = $urandom_range(19);
		if (sel < 12) begin
			case (sel)
			0:       v = 10'd0;
			1:       v = 10'd1;
			2:       v = 10'd2;
			3:       v = 10'd3;
			4:       v = 10'd7;
			5:       v = 10'd64;
			6:       v = 10'd100;
			7:       v = 10'd128;
			8:       v = 10'd200;
			9:       v = vkt_pkg::TOP_NORMAL_VER - 10'd1;
			10:      v = vkt_pkg::TOP_NORMAL_VER;
			default: v = vkt_pkg::SPECIAL_VER;
			endcase
		end else if (sel < 16)
			v = 10'($urandom_range(vkt_pkg::TOP_NORMAL_VER));
		else if (sel < 19)
			v = 10'($urandom_range(1023));
		else begin
			case ($urandom_range(3))
			0:       v = vkt_pkg::TOP_NORMAL_VER + 10'd1;
			1:       v = vkt_pkg::SPECIAL_VER - 10'd1;
			2:       v = vkt_pkg::SPECIAL_VER + 10'd1;
			default: v = '1;
			endcase
		end
		return v;
	endfunction

	// One random command; add_pct biases the table toward filling or emptying.
	task automatic send_random(input int add_pct);
		logic [1:0]                cmd;
		logic [vkt_pkg::KEY_W-1:0] k;
		int                        r;
		r = $urandom_range(99);
		if (r < add_pct)
			cmd = vkt_pkg::CMD_ADD;
		else begin
			r   = $urandom_range(99);
			cmd = (r < 40) ? vkt_pkg::CMD_DELETE :
				(r < 75) ? vkt_pkg::CMD_GET : vkt_pkg::CMD_LATEST;
		end
		case ($urandom_range(15))
		0:       k = '0;
		1:       k = '1;
		default: k = {$urandom, $urandom};
		endcase
		send_command(cmd, pick_version(), 1'($urandom_range(1)), k);
	endtask

	initial begin : stimulus
		int blk;
		int n;

		// hold reset, then release it on an edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every lookup misses
		send_command(vkt_pkg::CMD_LATEST, 10'd0, 1'b0, '0);
		send_command(vkt_pkg::CMD_GET,    10'd0, 1'b0, '0);
		send_command(vkt_pkg::CMD_DELETE, 10'd5, 1'b1, '1);
		// range check: just above the normal range, the top code, just below special
		send_command(vkt_pkg::CMD_ADD, vkt_pkg::TOP_NORMAL_VER + 10'd1, 1'b0,
			64'h0123_4567_89ab_cdef);
		send_command(vkt_pkg::CMD_ADD, '1, 1'b1, '1);
		send_command(vkt_pkg::CMD_ADD, vkt_pkg::SPECIAL_VER - 10'd1, 1'b0, 64'h1);
		// special version is stored and found by get, but skipped by latest
		send_command(vkt_pkg::CMD_ADD,    vkt_pkg::SPECIAL_VER, 1'b0, '1);
		send_command(vkt_pkg::CMD_LATEST, 10'd0,                1'b0, '0);
		send_command(vkt_pkg::CMD_GET,    vkt_pkg::SPECIAL_VER, 1'b0, '0);
		// version zero is a valid latest
		send_command(vkt_pkg::CMD_ADD,    10'd0, 1'b0, '0);
		send_command(vkt_pkg::CMD_LATEST, 10'd0, 1'b0, '0);
		// in use without overwrite, then replace in place
		send_command(vkt_pkg::CMD_ADD, vkt_pkg::TOP_NORMAL_VER, 1'b0, 64'hdead_beef_cafe_f00d);
		send_command(vkt_pkg::CMD_ADD, vkt_pkg::TOP_NORMAL_VER, 1'b0, 64'h5555_5555_5555_5555);
		send_command(vkt_pkg::CMD_ADD, vkt_pkg::TOP_NORMAL_VER, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
		send_command(vkt_pkg::CMD_GET, vkt_pkg::TOP_NORMAL_VER, 1'b0, '0);
		// fill to MAX_KEYS, then a new version is refused even with overwrite
		for (n = 1; n <= 5; n++)
			send_command(vkt_pkg::CMD_ADD, 10'(n), 1'b0, {$urandom, $urandom});
		send_command(vkt_pkg::CMD_ADD, 10'd6, 1'b0, 64'h6);
		send_command(vkt_pkg::CMD_ADD, 10'd6, 1'b1, 64'h6);
		// overwrite still works on a full table
		send_command(vkt_pkg::CMD_ADD, 10'd0, 1'b1, 64'h8000_0000_0000_0001);
		// delete the first slot and slide the rest down
		send_command(vkt_pkg::CMD_DELETE, vkt_pkg::SPECIAL_VER, 1'b0, '0);
		send_command(vkt_pkg::CMD_LATEST, 10'd0,                1'b0, '0);
		wait_drained();

		// random traffic with idling on both sides
		for (n = 0; n < 400; n++)
			send_random(35);

		// long stretch with no idling at all
		steady = 1'b1;
		for (n = 0; n < 300; n++)
			send_random(n < 150 ? 60 : 20);
		steady = 1'b0;
		wait_drained();

		// stall the sink while the sender keeps offering commands
		hold_request = 1'b1;
		for (n = 0; n < 40; n++)
			send_random(50);
		wait_drained();

		// alternate fill-heavy and drain-heavy blocks, pausing now and then
		for (blk = 0; blk < 10; blk++) begin
			for (n = 0; n < 100; n++)
				send_random((blk % 2 == 0) ? 60 : 15);
			if (blk % 3 == 2)
				wait_drained();
		end
		wait_drained();

		// let any stray result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d add, %0d delete, %0d get, %0d latest;",
			cmd_sent[0] + cmd_sent[1] + cmd_sent[2] + cmd_sent[3],
			cmd_sent[vkt_pkg::CMD_ADD], cmd_sent[vkt_pkg::CMD_DELETE],
			cmd_sent[vkt_pkg::CMD_GET], cmd_sent[vkt_pkg::CMD_LATEST]);
		$display("%0d results checked across edge cases, empty-to-full swings,", checked);
		$display("a %0d-cycle sink stall and drain pauses.", LONG_HOLD);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
